FILE: hw/rtl/clst_pkg.sv
package clst_pkg;

    // Fixed field widths of the request and result ports.
    localparam int KIND_W        = 2;
    localparam int VALUE_W       = 64;
    localparam int INDEX_W       = 10;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 11;

    // Default capacity of the list.
    localparam int DEPTH_DEFAULT = 1024;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request kinds.
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_POP    = 2'd2;

    // Result status codes.
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;
    localparam status_t ST_EMPTY = 2'd3;

endpackage

FILE: hw/rtl/compacting_list_store_top.sv
// Dense list of 64-bit words with insert-at-end, remove-at-index and pop. A request is
// taken when start is high and busy is low; its single result appears on status,
// popped_value and entry_count for exactly one cycle while done is high, and the receiver
// cannot stall it. An insert shows done in the next cycle, busy low. A pop reads the
// last entry and holds busy in the pop state. A remove-at that moves entries holds busy
// in the shift state; any other shows done in the next cycle. The remove-at time is set
// by the single entry memory, which moves one entry per cycle with one read and one
// write port. A new request may be issued in the cycle in which done is shown.
// entry_count always shows the current number of entries.
module compacting_list_store_top #(
    parameter int DEPTH = clst_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  clst_pkg::kind_t                      kind,
    input  logic [clst_pkg::VALUE_W-1:0]         value,
    input  logic [clst_pkg::INDEX_W-1:0]         index,
    output logic                                 done,
    output clst_pkg::status_t                    status,
    output logic [clst_pkg::VALUE_W-1:0]         popped_value,
    output logic [clst_pkg::ENTRY_COUNT_W-1:0]   entry_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > clst_pkg::INDEX_W) ? CW : clst_pkg::INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic                           done_reg, done_next;
    clst_pkg::status_t              status_reg, status_next;
    logic [clst_pkg::VALUE_W-1:0]   popped_reg, popped_next;

    logic [clst_pkg::VALUE_W-1:0]   mem [DEPTH];
    logic [clst_pkg::VALUE_W-1:0]   rd_data_reg;
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [clst_pkg::VALUE_W-1:0]   mem_wdata;

    logic                           accept;
    logic [XW-1:0]                  idx_x, cnt_x;
    logic [AW-1:0]                  idx_a;

    assign accept = start && !busy;
    assign idx_x  = XW'(index);
    assign cnt_x  = XW'(count_reg);
    assign idx_a  = AW'(index);

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Request sequencing and memory access control.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        popped_next = popped_reg;
        mem_we      = 1'b0;
        mem_waddr   = wr_ptr_reg;
        mem_wdata   = rd_data_reg;
        mem_re      = 1'b0;
        mem_raddr   = wr_ptr_reg + AW'(2);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        clst_pkg::KIND_INSERT:
                        begin
                            done_next   = 1'b1;
                            popped_next = '0;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                status_next = clst_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = clst_pkg::ST_DONE;
                                mem_we      = 1'b1;
                                mem_waddr   = AW'(count_reg);
                                mem_wdata   = value;
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        clst_pkg::KIND_REMOVE:
                        begin
                            popped_next = '0;
                            if (idx_x >= cnt_x)
                            begin
                                done_next   = 1'b1;
                                status_next = clst_pkg::ST_RANGE;
                            end
                            else
                            begin
                                status_next = clst_pkg::ST_DONE;
                                count_next  = count_reg - CW'(1);
                                // Entries above the index move down one place.
                                if ((idx_x + XW'(1)) < cnt_x)
                                begin
                                    mem_re      = 1'b1;
                                    mem_raddr   = idx_a + AW'(1);
                                    wr_ptr_next = idx_a;
                                    state_next  = S_SHIFT;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        clst_pkg::KIND_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = clst_pkg::ST_EMPTY;
                                popped_next = '0;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = clst_pkg::ST_DONE;
                            popped_next = '0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next   = 1'b1;
                status_next = clst_pkg::ST_DONE;
                popped_next = rd_data_reg;
                state_next  = S_IDLE;
            end
            S_SHIFT:
            begin
                // Write back the entry read in the previous cycle, one place lower.
                mem_we    = 1'b1;
                mem_waddr = wr_ptr_reg;
                mem_wdata = rd_data_reg;
                if ((wr_ptr_reg + AW'(1)) == AW'(count_reg))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = wr_ptr_reg + AW'(2);
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result and pointer payload.
    always_ff @(posedge clk)
    begin
        wr_ptr_reg <= wr_ptr_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = clst_pkg::ENTRY_COUNT_W'(count_reg);

endmodule

FILE: hw/rtl/clst_checker.sv
module clst_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  clst_pkg::kind_t                      kind,
    input  logic                                 done,
    input  clst_pkg::status_t                    status,
    input  logic [clst_pkg::VALUE_W-1:0]         popped_value,
    input  logic [clst_pkg::ENTRY_COUNT_W-1:0]   entry_count
);

    // An insert always completes in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == clst_pkg::KIND_INSERT) |=> (done && !busy))
        else $error("insert transaction did not complete in one cycle");

    // A pop on an empty list reports empty right away.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == clst_pkg::KIND_POP && entry_count == '0)
        |=> (done && status == clst_pkg::ST_EMPTY))
        else $error("pop on empty list not reported");

    // A failed transaction never returns a popped word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != clst_pkg::ST_DONE) |-> (popped_value == '0))
        else $error("failed transaction returned a nonzero word");

    // An empty report leaves the list empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == clst_pkg::ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind compacting_list_store_top clst_checker u_clst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .done         (done),
    .status       (status),
    .popped_value (popped_value),
    .entry_count  (entry_count)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import clst_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 12;

    // Kind code 3 has no meaning; the block must ignore it.
    localparam kind_t KIND_UNUSED = 2'd3;

    // Idle patterns of the request side, rotated every few dozen transactions.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_HEAVY = 1;
    localparam int IDLE_LIGHT = 2;
    localparam int IDLE_MODES = 3;
    localparam int IDLE_SPAN = 40;

    typedef struct packed {
        status_t                    status;
        logic [VALUE_W-1:0]         popped;
        logic [ENTRY_COUNT_W-1:0]   count;
    } list_result_t;

    typedef struct packed {
        kind_t                      kind;
        logic [VALUE_W-1:0]         value;
        logic [INDEX_W-1:0]         index;
        logic                       typed;
        list_result_t               result;
    } list_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    kind_t                      kind = KIND_INSERT;
    logic [VALUE_W-1:0]         value = '0;
    logic [INDEX_W-1:0]         index = '0;
    logic                       done;
    status_t                    status;
    logic [VALUE_W-1:0]         popped_value;
    logic [ENTRY_COUNT_W-1:0]   entry_count;

    // Shadow copy of the list contents and its length.
    logic [VALUE_W-1:0]         shadow_list [LIST_DEPTH];
    int unsigned                shadow_len = 0;

    list_result_t               pending_results [$];
    int                         fail_count = 0;
    int unsigned                random_sent = 0;

    // Directed transactions: empty list, word extremes, every kind, the empty and range error codes.
    list_row_t directed_rows [22] = '{
        '{KIND_POP,    64'd0,                  10'd0,    1'b1, '{ST_EMPTY, 64'd0, 11'd0}},
        '{KIND_REMOVE, 64'd0,                  10'd0,    1'b1, '{ST_RANGE, 64'd0, 11'd0}},
        '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b1, '{ST_RANGE, 64'd0, 11'd0}},
        '{KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023, 1'b1, '{ST_DONE,  64'd0, 11'd0}},
        '{KIND_INSERT, 64'd0,                  10'd1023, 1'b1, '{ST_DONE,  64'd0, 11'd1}},
        '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd2}},
        '{KIND_POP,    64'd0,                  10'd0,    1'b1,
          '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 11'd1}},
        '{KIND_INSERT, 64'h8000_0000_0000_0000, 10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd2}},
        '{KIND_INSERT, 64'h0000_0000_0000_0001, 10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd3}},
        '{KIND_INSERT, 64'h5555_5555_5555_5555, 10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd4}},
        '{KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd5}},
        '{KIND_REMOVE, 64'd0,                  10'd5,    1'b1, '{ST_RANGE, 64'd0, 11'd5}},
        '{KIND_REMOVE, 64'd0,                  10'd1023, 1'b1, '{ST_RANGE, 64'd0, 11'd5}},
        '{KIND_REMOVE, 64'd0,                  10'd0,    1'b1, '{ST_DONE,  64'd0, 11'd4}},
        '{KIND_REMOVE, 64'd0,                  10'd3,    1'b1, '{ST_DONE,  64'd0, 11'd3}},
        '{KIND_REMOVE, 64'd0,                  10'd1,    1'b1, '{ST_DONE,  64'd0, 11'd2}},
        '{KIND_POP,    64'd0,                  10'd0,    1'b1,
          '{ST_DONE, 64'h5555_5555_5555_5555, 11'd1}},
        '{KIND_UNUSED, 64'h1234_5678_9ABC_DEF0, 10'd512,  1'b1, '{ST_DONE,  64'd0, 11'd1}},
        '{KIND_POP,    64'd0,                  10'd0,    1'b1,
          '{ST_DONE, 64'h8000_0000_0000_0000, 11'd0}},
        '{KIND_POP,    64'd0,                  10'd0,    1'b1, '{ST_EMPTY, 64'd0, 11'd0}},
        '{KIND_INSERT, 64'hDEAD_BEEF_0123_4567, 10'd0,    1'b0, '0},
        '{KIND_POP,    64'd0,                  10'd0,    1'b0, '0}
    };

    compacting_list_store_top #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .value(value),
        .index(index),
        .done(done),
        .status(status),
        .popped_value(popped_value),
        .entry_count(entry_count)
    );

    // Free-running clock.
    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #100ms;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the shadow list and return the result it must produce.
    function automatic list_result_t apply_list_request(kind_t k, logic [VALUE_W-1:0] v,
                                                        logic [INDEX_W-1:0] idx);
        list_result_t res;
        res = '0;
        res.status = ST_DONE;
        case (k)
            KIND_INSERT:
            begin
                if (shadow_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_len] = v;
                    shadow_len++;
                end
            end
            KIND_REMOVE:
            begin
                if (idx >= shadow_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int unsigned i = idx + 1; i < shadow_len; i++)
                        shadow_list[i - 1] = shadow_list[i];
                    shadow_len--;
                end
            end
            KIND_POP:
            begin
                if (shadow_len == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    shadow_len--;
                    res.popped = shadow_list[shadow_len];
                end
            end
            default:
            begin
                // Unused kind: nothing changes.
            end
        endcase
        res.count = shadow_len[ENTRY_COUNT_W-1:0];
        return res;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic issue_request(kind_t k, logic [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx,
                                 logic typed, list_result_t typed_res);
        list_result_t predicted;
        start <= 1'b1;
        kind <= k;
        value <= v;
        index <= idx;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_list_request(k, v, idx);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Stop requesting until every outstanding result has been seen.
    task automatic drain_results();
        while (pending_results.size() != 0)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Random gap before a transaction, following the current idle pattern.
    task automatic request_gap();
        int unsigned idle_pct;
        case ((random_sent / IDLE_SPAN) % IDLE_MODES)
            IDLE_HEAVY: idle_pct = 85;
            IDLE_LIGHT: idle_pct = 14;
            default:    idle_pct = 0;
        endcase
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        if ($urandom_range(199) == 0)
            drain_results();
        random_sent++;
    endtask

    // Random request; inserts dominate while the list is below the target length.
    task automatic issue_random(int unsigned target_len, int unsigned grow_pct);
        kind_t                  k;
        logic [VALUE_W-1:0]     v;
        logic [INDEX_W-1:0]     idx;
        int unsigned            pick;
        int unsigned            insert_pct;
        insert_pct = (shadow_len < target_len) ? grow_pct : 30;
        if ($urandom_range(99) < insert_pct)
            k = KIND_INSERT;
        else
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                k = KIND_UNUSED;
            else if (pick < 5)
                k = KIND_REMOVE;
            else
                k = KIND_POP;
        end

        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase

        // Remove targets: anywhere in the index range, the last entry, or any live entry.
        pick = $urandom_range(9);
        if (pick < 4 || k != KIND_REMOVE || shadow_len == 0)
            idx = INDEX_W'($urandom_range(2 ** INDEX_W - 1));
        else if (pick < 7)
            idx = INDEX_W'(shadow_len - 1);
        else
            idx = INDEX_W'($urandom_range(shadow_len - 1));

        issue_request(k, v, idx, 1'b0, '0);
    endtask

    // Check every result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d, popped_value %h, count %0d",
                       status, popped_value, entry_count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (popped_value !== want.popped)
                begin
                    $error("popped_value: expected %h, actual %h", want.popped, popped_value);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: directed table, then a near-empty phase, then a fill to capacity.
    initial
    begin
        bit             reached_full;
        int unsigned    beyond_full;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].kind, directed_rows[i].value,
                          directed_rows[i].index, directed_rows[i].typed,
                          directed_rows[i].result);
        drain_results();

        // Short list: empty pops, out-of-range removes, cheap shifts.
        for (int n = 0; n < 150; n++)
        begin
            request_gap();
            issue_random(6, 60);
        end
        drain_results();

        // Grow to capacity, then keep working around the full boundary.
        reached_full = 1'b0;
        beyond_full = 0;
        while (beyond_full < 60)
        begin
            request_gap();
            issue_random(LIST_DEPTH, 94);
            if (shadow_len == LIST_DEPTH)
                reached_full = 1'b1;
            if (reached_full)
                beyond_full++;
        end

        drain_results();
        repeat (LIST_DEPTH + 16) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
